FILE: hdl/pcx_rle_decoder_defines.svh
// assertion macros for the pcx run-length decoder
`ifndef PCX_RLE_DECODER_DEFINES_SVH
`define PCX_RLE_DECODER_DEFINES_SVH

// same-cycle implication
`define PCX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pcx_rle_pkg.sv
package pcx_rle_pkg;

  localparam int unsigned DefaultHeaderBytes = 128;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned TotalW = 17;
  localparam int unsigned PosW = 16;
  localparam int unsigned RunW = 6;

  localparam logic [7:0] RunMark = 8'd192;
  localparam logic [TotalW-1:0] PixelTotalReset = 17'd64000;
  localparam logic [TotalW-1:0] PixelTotalMax = 17'd65536;

  localparam logic KindHeader = 1'b0;
  localparam logic KindPixel = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA,
    PH_RUNVAL,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic            kind;
    logic [PosW-1:0] pos;
    logic [7:0]      val;
    logic [RunW-1:0] cnt;
    logic            done;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: hdl/pcx_rle_decoder.sv
// PCX run-length decoder. A front part takes one file byte per cycle into a two-entry
// command queue: header bytes and literal pixels become one result each, a run marker
// byte gives no result, and the byte after it becomes a run of up to 63 pixels. The back
// part sends one result per cycle from that queue while the receiver is ready, so a run
// of n pixels holds the output for n results and intake stops once the queue is full;
// each marker byte takes intake without giving a result. After pixel_total pixels the
// image is complete and later bytes are taken and dropped until reset. pixel_total is
// written through the cfg channel (0 acts as 1, values above 65536 as 65536).
module pcx_rle_decoder #(
  parameter int unsigned HEADER_BYTES = pcx_rle_pkg::DefaultHeaderBytes
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pcx_rle_pkg::TotalW-1:0]  cfg_pixel_total_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      data_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            item_kind_o,
  output logic [pcx_rle_pkg::PosW-1:0]    position_o,
  output logic [7:0]                      value_o,
  output logic                            last_o,
  output logic                            image_done_o
);
  import pcx_rle_pkg::*;

  `include "pcx_rle_decoder_defines.svh"

  cmd_t      push_cmd, pop_cmd;
  logic      push, pop;
  q_status_t q_status;

  pcx_rle_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_pixel_total_i,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  pcx_rle_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i   (push),
    .wdata_i  (push_cmd),
    .pop_i    (pop),
    .rdata_o  (pop_cmd),
    .status_o (q_status)
  );

  pcx_rle_back u_back (
    .clk_i,
    .rst_ni,
    .q_status_i (q_status),
    .cmd_i      (pop_cmd),
    .pop_o      (pop),
    .out_valid_o,
    .out_ready_i,
    .item_kind_o,
    .position_o,
    .value_o,
    .last_o,
    .image_done_o
  );

  `PCX_ASSERT_NOW(a_done_is_last_pixel, out_valid_o && image_done_o,
                  last_o && item_kind_o, "image_done on a result that is not a final pixel")
  `PCX_ASSERT_NOW(a_header_single, out_valid_o && (item_kind_o == KindHeader),
                  last_o && !image_done_o, "header result not single")
  `PCX_ASSERT_NEXT(a_quiet_after_done, out_valid_o && out_ready_i && image_done_o,
                   !out_valid_o, "result after image completion")

endmodule

FILE: hdl/pcx_rle_front.sv
module pcx_rle_front #(
  parameter int unsigned HEADER_BYTES = pcx_rle_pkg::DefaultHeaderBytes
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pcx_rle_pkg::TotalW-1:0]  cfg_pixel_total_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      data_byte_i,
  input  pcx_rle_pkg::q_status_t          q_status_i,
  output logic                            push_o,
  output pcx_rle_pkg::cmd_t               cmd_o
);
  import pcx_rle_pkg::*;

  localparam int unsigned HcW = $clog2(HEADER_BYTES + 2);

  phase_e            phase_q, phase_d;
  logic [HcW-1:0]    header_count_q, header_count_d;
  logic [RunW-1:0]   pending_q, pending_d;
  logic [TotalW-1:0] pixel_count_q, pixel_count_d;
  logic [TotalW-1:0] pixel_total_q;

  logic [TotalW-1:0] total;
  logic [TotalW-1:0] remain;
  logic [RunW-1:0]   run_n;
  logic [TotalW-1:0] count_run;
  logic [HcW:0]      hc_inc;
  logic              reached;
  logic              accept;
  logic              is_mark;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_status_i.full;
  assign accept      = in_valid_i && in_ready_o;
  assign is_mark     = data_byte_i >= RunMark;

  always_comb begin
    if (pixel_total_q == '0) begin
      total = TotalW'(1);
    end else if (pixel_total_q > PixelTotalMax) begin
      total = PixelTotalMax;
    end else begin
      total = pixel_total_q;
    end
  end

  assign reached   = pixel_count_q >= total;
  assign remain    = total - pixel_count_q;
  assign run_n     = ({{(TotalW-RunW){1'b0}}, pending_q} > remain) ? remain[RunW-1:0]
                                                                   : pending_q;
  assign count_run = pixel_count_q + {{(TotalW-RunW){1'b0}}, run_n};
  assign hc_inc    = {1'b0, header_count_q} + (HcW+1)'(1);

  // next state
  always_comb begin
    phase_d        = phase_q;
    header_count_d = header_count_q;
    pending_d      = pending_q;
    pixel_count_d  = pixel_count_q;
    if (accept) begin
      unique case (phase_q)
        PH_HEADER: begin
          header_count_d = hc_inc[HcW-1:0];
          if (hc_inc >= (HcW+1)'(HEADER_BYTES)) begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          if (reached) begin
            phase_d = PH_DONE;
          end else if (is_mark) begin
            pending_d = data_byte_i[RunW-1:0];
            phase_d   = PH_RUNVAL;
          end else begin
            pixel_count_d = pixel_count_q + TotalW'(1);
            if (pixel_count_q + TotalW'(1) == total) begin
              phase_d = PH_DONE;
            end
          end
        end
        PH_RUNVAL: begin
          if (reached) begin
            phase_d = PH_DONE;
          end else begin
            pixel_count_d = count_run;
            pending_d     = '0;
            phase_d       = (count_run >= total) ? PH_DONE : PH_DATA;
          end
        end
        PH_DONE: begin
          phase_d = PH_DONE;
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase
    end
  end

  // queue command
  always_comb begin
    push_o      = 1'b0;
    cmd_o.kind  = KindPixel;
    cmd_o.pos   = pixel_count_q[PosW-1:0];
    cmd_o.val   = data_byte_i;
    cmd_o.cnt   = RunW'(1);
    cmd_o.done  = 1'b0;
    unique case (phase_q)
      PH_HEADER: begin
        push_o     = accept;
        cmd_o.kind = KindHeader;
        cmd_o.pos  = PosW'(header_count_q);
      end
      PH_DATA: begin
        push_o     = accept && !reached && !is_mark;
        cmd_o.done = (pixel_count_q + TotalW'(1)) == total;
      end
      PH_RUNVAL: begin
        push_o     = accept && !reached && (run_n != '0);
        cmd_o.cnt  = run_n;
        cmd_o.done = count_run == total;
      end
      PH_DONE: begin
        push_o = 1'b0;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= (HEADER_BYTES == 0) ? PH_DATA : PH_HEADER;
      header_count_q <= '0;
      pending_q      <= '0;
      pixel_count_q  <= '0;
      pixel_total_q  <= PixelTotalReset;
    end else begin
      phase_q        <= phase_d;
      header_count_q <= header_count_d;
      pending_q      <= pending_d;
      pixel_count_q  <= pixel_count_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pixel_total_q <= cfg_pixel_total_i;
      end
    end
  end

endmodule

FILE: hdl/pcx_rle_fifo.sv
module pcx_rle_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  pcx_rle_pkg::cmd_t       wdata_i,
  input  logic                    pop_i,
  output pcx_rle_pkg::cmd_t       rdata_o,
  output pcx_rle_pkg::q_status_t  status_o
);
  import pcx_rle_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign status_o.full  = count_q == CntW'(QueueDepth);
  assign status_o.empty = count_q == '0;
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign rdata_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

FILE: hdl/pcx_rle_back.sv
module pcx_rle_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pcx_rle_pkg::q_status_t        q_status_i,
  input  pcx_rle_pkg::cmd_t             cmd_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          item_kind_o,
  output logic [pcx_rle_pkg::PosW-1:0]  position_o,
  output logic [7:0]                    value_o,
  output logic                          last_o,
  output logic                          image_done_o
);
  import pcx_rle_pkg::*;

  logic            active_q, active_d;
  logic            kind_q;
  logic [PosW-1:0] pos_q;
  logic [7:0]      val_q;
  logic [RunW-1:0] rem_q;
  logic            done_q;
  logic            xfer;
  logic            final_one;

  assign xfer      = active_q && out_ready_i;
  assign final_one = rem_q == RunW'(1);
  assign pop_o     = !q_status_i.empty && (!active_q || (xfer && final_one));

  always_comb begin
    active_d = active_q;
    if (pop_o) begin
      active_d = 1'b1;
    end else if (xfer && final_one) begin
      active_d = 1'b0;
    end
  end

  assign out_valid_o  = active_q;
  assign item_kind_o  = kind_q;
  assign position_o   = pos_q;
  assign value_o      = val_q;
  assign last_o       = final_one;
  assign image_done_o = done_q && final_one;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= cmd_i.kind;
      pos_q  <= cmd_i.pos;
      val_q  <= cmd_i.val;
      rem_q  <= cmd_i.cnt;
      done_q <= cmd_i.done;
    end else if (xfer && !final_one) begin
      pos_q <= pos_q + PosW'(1);
      rem_q <= rem_q - RunW'(1);
    end
  end

endmodule

FILE: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pcx_rle_pkg::*;

  localparam int HdrBytes = DefaultHeaderBytes;
  localparam int IdleLimit = 4000;
  localparam int HoldCycles = 300;
  localparam int SettleCycles = 16;

  typedef struct packed {
    logic            kind;
    logic [PosW-1:0] pos;
    logic [7:0]      val;
    logic            last;
    logic            done;
  } pix_rec_t;

  typedef struct packed {
    logic     fill;
    logic [7:0] b;
    logic     typed;
    logic     has_res;
    pix_rec_t res;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [TotalW-1:0] cfg_pixel_total_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [7:0]        data_byte_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              item_kind_o;
  logic [PosW-1:0]   position_o;
  logic [7:0]        value_o;
  logic              last_o;
  logic              image_done_o;

  // decoder model state
  phase_e            dec_phase = PH_HEADER;
  int                hdr_cnt = 0;
  int                run_len = 0;
  int                pix_cnt = 0;
  logic [TotalW-1:0] pixel_total = PixelTotalReset;

  pix_rec_t decoded_q[$];
  row_t     script[$];

  int errors = 0;
  int n_bytes = 0;
  int n_headers = 0;
  int n_pixels = 0;
  int n_done = 0;
  int last_n = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;
  bit gaps_on = 1'b1;

  pcx_rle_decoder #(
    .HEADER_BYTES(HdrBytes)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_pixel_total_i (cfg_pixel_total_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .item_kind_o       (item_kind_o),
    .position_o        (position_o),
    .value_o           (value_o),
    .last_o            (last_o),
    .image_done_o      (image_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int image_limit();
    if (pixel_total == '0) return 1;
    if (pixel_total > PixelTotalMax) return int'(PixelTotalMax);
    return int'(pixel_total);
  endfunction

  function automatic void push_rec(input logic kind, input int pos, input logic [7:0] val,
                                   input logic last, input logic done);
    pix_rec_t r;
    r.kind = kind;
    r.pos  = PosW'(pos);
    r.val  = val;
    r.last = last;
    r.done = done;
    decoded_q.push_back(r);
    last_n++;
  endfunction

  function automatic row_t mk(input logic fill, input logic [7:0] b, input logic typed,
                              input logic has_res, input logic kind, input int pos,
                              input logic [7:0] val);
    row_t r;
    r.fill     = fill;
    r.b        = b;
    r.typed    = typed;
    r.has_res  = has_res;
    r.res.kind = kind;
    r.res.pos  = PosW'(pos);
    r.res.val  = val;
    r.res.last = 1'b1;
    r.res.done = 1'b0;
    return r;
  endfunction

  // expected results of one accepted file byte
  task automatic decode_byte(input logic [7:0] b);
    int total;
    int n;
    total = image_limit();
    last_n = 0;
    if (dec_phase == PH_HEADER) begin
      push_rec(KindHeader, hdr_cnt, b, 1'b1, 1'b0);
      hdr_cnt++;
      if (hdr_cnt >= HdrBytes) dec_phase = PH_DATA;
    end else if (dec_phase == PH_DONE) begin
    end else if (pix_cnt >= total) begin
      dec_phase = PH_DONE;
    end else if (dec_phase == PH_DATA) begin
      if (b >= RunMark) begin
        run_len = int'(b[RunW-1:0]);
        dec_phase = PH_RUNVAL;
      end else begin
        pix_cnt++;
        push_rec(KindPixel, pix_cnt - 1, b, 1'b1, pix_cnt == total);
        if (pix_cnt == total) dec_phase = PH_DONE;
      end
    end else begin
      n = run_len;
      if (n > total - pix_cnt) n = total - pix_cnt;
      for (int i = 0; i < n; i++) begin
        push_rec(KindPixel, pix_cnt, b, i + 1 == n, pix_cnt + 1 == total);
        pix_cnt++;
      end
      run_len = 0;
      dec_phase = (pix_cnt >= total) ? PH_DONE : PH_DATA;
    end
  endtask

  task automatic put_byte(input logic [7:0] b);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    data_byte_i = b;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(b);
    n_bytes++;
  endtask

  task automatic set_pixel_total(input logic [TotalW-1:0] v);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i       = 1'b1;
    cfg_pixel_total_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    pixel_total = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // mostly literals and marker/value pairs, some stray bytes
  task automatic random_bytes();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      put_byte(8'($urandom_range(0, 191)));
    end else if (r < 8) begin
      put_byte(RunMark | 8'($urandom_range(0, 63)));
      put_byte(8'($urandom_range(0, 255)));
    end else if (r == 8) begin
      put_byte(8'($urandom_range(0, 255)));
    end else begin
      put_byte(RunMark | 8'($urandom_range(0, 63)));
      put_byte(RunMark | 8'($urandom_range(0, 63)));
    end
  endtask

  // receiver
  always begin
    @(negedge clk_i);
    if (hold_req) begin
      hold_req    = 1'b0;
      out_ready_i = 1'b0;
      for (int k = 1; k < HoldCycles; k++) @(negedge clk_i);
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_ready_i = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    pix_rec_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        report_error($sformatf("unexpected result kind %0b pos %0d", item_kind_o, position_o));
      end else begin
        want = decoded_q.pop_front();
        if (item_kind_o !== want.kind)
          report_error($sformatf("pos %0d kind %0b, want %0b", want.pos, item_kind_o,
                                 want.kind));
        if (position_o !== want.pos)
          report_error($sformatf("position %0d, want %0d", position_o, want.pos));
        if (value_o !== want.val)
          report_error($sformatf("pos %0d value %0d, want %0d", want.pos, value_o, want.val));
        if (last_o !== want.last)
          report_error($sformatf("pos %0d last %0b, want %0b", want.pos, last_o, want.last));
        if (image_done_o !== want.done)
          report_error($sformatf("pos %0d image_done %0b, want %0b", want.pos, image_done_o,
                                 want.done));
        if (want.kind == KindHeader) n_headers++;
        else n_pixels++;
        if (want.done) n_done++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transfer for %0d cycles", IdleLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    // header: both extremes first, random fill, then a last byte that looks like a marker
    script.push_back(mk(1'b0, 8'h00, 1'b1, 1'b1, KindHeader, 0, 8'h00));
    script.push_back(mk(1'b0, 8'hFF, 1'b1, 1'b1, KindHeader, 1, 8'hFF));
    script.push_back(mk(1'b1, 8'h00, 1'b0, 1'b0, KindHeader, 0, 8'h00));
    script.push_back(mk(1'b0, 8'hC5, 1'b0, 1'b0, KindHeader, 0, 8'h00));
    // literals at the bottom and top of the range
    script.push_back(mk(1'b0, 8'h00, 1'b1, 1'b1, KindPixel, 0, 8'h00));
    script.push_back(mk(1'b0, 8'hBF, 1'b1, 1'b1, KindPixel, 1, 8'hBF));
    // zero-length run eats its value byte
    script.push_back(mk(1'b0, 8'hC0, 1'b1, 1'b0, KindPixel, 0, 8'h00));
    script.push_back(mk(1'b0, 8'h55, 1'b1, 1'b0, KindPixel, 0, 8'h00));
    // longest run, then a run of one
    script.push_back(mk(1'b0, 8'hFF, 1'b1, 1'b0, KindPixel, 0, 8'h00));
    script.push_back(mk(1'b0, 8'h00, 1'b0, 1'b0, KindPixel, 0, 8'h00));
    script.push_back(mk(1'b0, 8'hC1, 1'b1, 1'b0, KindPixel, 0, 8'h00));
    script.push_back(mk(1'b0, 8'hFF, 1'b0, 1'b0, KindPixel, 0, 8'h00));
    // run value that looks like a marker
    script.push_back(mk(1'b0, 8'hC3, 1'b1, 1'b0, KindPixel, 0, 8'h00));
    script.push_back(mk(1'b0, 8'hC0, 1'b0, 1'b0, KindPixel, 0, 8'h00));
    script.push_back(mk(1'b0, 8'hE5, 1'b0, 1'b0, KindPixel, 0, 8'h00));
    script.push_back(mk(1'b0, 8'hAA, 1'b0, 1'b0, KindPixel, 0, 8'h00));
    script.push_back(mk(1'b0, 8'h01, 1'b0, 1'b0, KindPixel, 0, 8'h00));
    script.push_back(mk(1'b0, 8'h80, 1'b0, 1'b0, KindPixel, 0, 8'h00));
    script.push_back(mk(1'b0, 8'h7F, 1'b0, 1'b0, KindPixel, 0, 8'h00));
    script.push_back(mk(1'b0, 8'hDF, 1'b0, 1'b0, KindPixel, 0, 8'h00));
    script.push_back(mk(1'b0, 8'h33, 1'b0, 1'b0, KindPixel, 0, 8'h00));
    script.push_back(mk(1'b0, 8'hFE, 1'b0, 1'b0, KindPixel, 0, 8'h00));
    script.push_back(mk(1'b0, 8'hFF, 1'b0, 1'b0, KindPixel, 0, 8'h00));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (script[i]) begin
      if (script[i].fill) begin
        while (hdr_cnt < HdrBytes - 1) put_byte(8'($urandom_range(0, 255)));
      end else begin
        put_byte(script[i].b);
        if (script[i].typed) begin
          repeat (last_n) void'(decoded_q.pop_back());
          if (script[i].has_res) decoded_q.push_back(script[i].res);
        end
      end
    end

    // reset total still in force; long receiver hold-off
    hold_req = 1'b1;
    repeat (20) random_bytes();
    set_pixel_total('1);
    repeat (12) random_bytes();
    set_pixel_total(PixelTotalMax);
    repeat (8) random_bytes();

    gaps_on = 1'b0;
    if ($urandom_range(0, 3) == 0) begin
      // total lowered below the pixels already out
      set_pixel_total('0);
      repeat (12) put_byte(8'($urandom_range(0, 255)));
    end else begin
      set_pixel_total(TotalW'(pix_cnt + $urandom_range(40, 120)));
      while (dec_phase != PH_DONE) random_bytes();
      repeat (12) put_byte(8'($urandom_range(0, 255)));
      set_pixel_total('0);
      repeat (4) put_byte(8'($urandom_range(0, 255)));
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (2 * SettleCycles) @(posedge clk_i);

    $display("covered %0d file bytes: %0d header and %0d pixel results, %0d image completion",
             n_bytes, n_headers, n_pixels, n_done);
    $display("last pixel_total %0d, decoder ended in %s after %0d pixels",
             pixel_total, dec_phase.name(), pix_cnt);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
